### rtl/lphf_pkg.sv
// ----------------------------------------------------------------------------
// lphf_pkg
// Shared types and constants for the lane point homography filter: register
// map, register reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package lphf_pkg;

  localparam int COEF_W = 32;
  localparam int OFS_W  = 10;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_COEF_X_FROM_X   = 3'd0,
    REG_COEF_X_FROM_Y   = 3'd1,
    REG_COEF_X_CONST    = 3'd2,
    REG_COEF_Y_FROM_Y   = 3'd3,
    REG_COEF_Y_CONST    = 3'd4,
    REG_COEF_DEN_FROM_Y = 3'd5,
    REG_LATERAL_OFFSET  = 3'd6
  } lphf_reg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_x_from_x;
    logic signed [COEF_W-1:0] coef_x_from_y;
    logic signed [COEF_W-1:0] coef_x_const;
    logic signed [COEF_W-1:0] coef_y_from_y;
    logic signed [COEF_W-1:0] coef_y_const;
    logic signed [COEF_W-1:0] coef_den_from_y;
    logic        [OFS_W-1:0]  lateral_offset;
  } lphf_cfg_t;

  localparam logic signed [COEF_W-1:0] RST_COEF_X_FROM_X   = -32'sd146432;
  localparam logic signed [COEF_W-1:0] RST_COEF_X_FROM_Y   = -32'sd2077924;
  localparam logic signed [COEF_W-1:0] RST_COEF_X_CONST    = 32'sd389996544;
  localparam logic signed [COEF_W-1:0] RST_COEF_Y_FROM_Y   = -32'sd3049245;
  localparam logic signed [COEF_W-1:0] RST_COEF_Y_CONST    = 32'sd562808604;
  localparam logic signed [COEF_W-1:0] RST_COEF_DEN_FROM_Y = -32'sd6372;
  localparam logic        [OFS_W-1:0]  RST_LATERAL_OFFSET  = 10'd230;

endpackage

### rtl/lphf_regs.sv
// ----------------------------------------------------------------------------
// lphf_regs
// APB-style configuration registers holding the homography coefficients and
// the lateral offset.
// ----------------------------------------------------------------------------
module lphf_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lphf_pkg::ADDR_W-1:0]    paddr,
  input  logic [lphf_pkg::DATA_W-1:0]    pwdata,
  output logic [lphf_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output lphf_pkg::lphf_cfg_t            cfg
);

  lphf_pkg::lphf_reg_t reg_sel;
  logic                wr_en;

  assign reg_sel = lphf_pkg::lphf_reg_t'(paddr[lphf_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_x_from_x   <= lphf_pkg::RST_COEF_X_FROM_X;
      cfg.coef_x_from_y   <= lphf_pkg::RST_COEF_X_FROM_Y;
      cfg.coef_x_const    <= lphf_pkg::RST_COEF_X_CONST;
      cfg.coef_y_from_y   <= lphf_pkg::RST_COEF_Y_FROM_Y;
      cfg.coef_y_const    <= lphf_pkg::RST_COEF_Y_CONST;
      cfg.coef_den_from_y <= lphf_pkg::RST_COEF_DEN_FROM_Y;
      cfg.lateral_offset  <= lphf_pkg::RST_LATERAL_OFFSET;
    end else if (wr_en) begin
      case (reg_sel)
        lphf_pkg::REG_COEF_X_FROM_X:   cfg.coef_x_from_x   <= pwdata;
        lphf_pkg::REG_COEF_X_FROM_Y:   cfg.coef_x_from_y   <= pwdata;
        lphf_pkg::REG_COEF_X_CONST:    cfg.coef_x_const    <= pwdata;
        lphf_pkg::REG_COEF_Y_FROM_Y:   cfg.coef_y_from_y   <= pwdata;
        lphf_pkg::REG_COEF_Y_CONST:    cfg.coef_y_const    <= pwdata;
        lphf_pkg::REG_COEF_DEN_FROM_Y: cfg.coef_den_from_y <= pwdata;
        lphf_pkg::REG_LATERAL_OFFSET:  cfg.lateral_offset  <= pwdata[lphf_pkg::OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      lphf_pkg::REG_COEF_X_FROM_X:   prdata = cfg.coef_x_from_x;
      lphf_pkg::REG_COEF_X_FROM_Y:   prdata = cfg.coef_x_from_y;
      lphf_pkg::REG_COEF_X_CONST:    prdata = cfg.coef_x_const;
      lphf_pkg::REG_COEF_Y_FROM_Y:   prdata = cfg.coef_y_from_y;
      lphf_pkg::REG_COEF_Y_CONST:    prdata = cfg.coef_y_const;
      lphf_pkg::REG_COEF_DEN_FROM_Y: prdata = cfg.coef_den_from_y;
      lphf_pkg::REG_LATERAL_OFFSET:  prdata = lphf_pkg::DATA_W'(cfg.lateral_offset);
      default:                       prdata = '0;
    endcase
  end

endmodule

### rtl/lphf_front.sv
// ----------------------------------------------------------------------------
// lphf_front
// Four pipeline stages: image window check, coefficient products, numerator
// and denominator sums, then magnitudes, quotient signs and the zero
// denominator check.
// ----------------------------------------------------------------------------
module lphf_front #(
  parameter int IMG_WIDTH      = 640,
  parameter int IMG_HEIGHT     = 480,
  parameter int COEF_FRAC_BITS = 20,
  parameter int CW             = 10,
  parameter int NW             = 45
) (
  input  logic                clk,
  input  logic                rst,
  input  lphf_pkg::lphf_cfg_t cfg,
  input  logic                pt_valid,
  output logic                pt_ready,
  input  logic signed [15:0]  pix_x,
  input  logic signed [15:0]  pix_y,
  input  logic                lane_sel,
  input  logic                last_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [NW-1:0]       den_mag,
  output logic [NW-1:0]       mag_x,
  output logic [NW-1:0]       mag_y,
  output logic                neg_x,
  output logic                neg_y,
  output logic                lane,
  output logic                last
);

  localparam int PW = lphf_pkg::COEF_W + CW + 1;
  localparam logic signed [NW-1:0] DEN_ONE = NW'(1) << COEF_FRAC_BITS;

  logic          va, vb, vc, vd;
  logic          rdy_a, rdy_b, rdy_c, rdy_d;
  logic          in_img;
  logic [CW-1:0] xa, ya;
  logic          la, ta, lb, tb, lc, tc;

  logic signed [PW-1:0] pxx, pxy, pyy, pdy;
  logic signed [NW-1:0] numx, numy, den;

  assign in_img = (pix_x > 0) && (pix_x < IMG_WIDTH) && (pix_y > 0) && (pix_y < IMG_HEIGHT);

  assign rdy_d    = !vd || out_ready;
  assign rdy_c    = !vc || rdy_d;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign pt_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (rdy_a) va <= pt_valid && in_img;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
      if (rdy_d) vd <= vc && (den != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && pt_valid) begin
      xa <= pix_x[CW-1:0];
      ya <= pix_y[CW-1:0];
      la <= lane_sel;
      ta <= last_in;
    end
    if (rdy_b && va) begin
      pxx <= $signed(cfg.coef_x_from_x)   * $signed({1'b0, xa});
      pxy <= $signed(cfg.coef_x_from_y)   * $signed({1'b0, ya});
      pyy <= $signed(cfg.coef_y_from_y)   * $signed({1'b0, ya});
      pdy <= $signed(cfg.coef_den_from_y) * $signed({1'b0, ya});
      lb  <= la;
      tb  <= ta;
    end
    if (rdy_c && vb) begin
      numx <= NW'(pxx) + NW'(pxy) + NW'($signed(cfg.coef_x_const));
      numy <= NW'(pyy) + NW'($signed(cfg.coef_y_const));
      den  <= NW'(pdy) + DEN_ONE;
      lc   <= lb;
      tc   <= tb;
    end
    if (rdy_d && vc) begin
      mag_x   <= numx[NW-1] ? NW'(-numx) : NW'(numx);
      mag_y   <= numy[NW-1] ? NW'(-numy) : NW'(numy);
      den_mag <= den[NW-1] ? NW'(-den) : NW'(den);
      neg_x   <= numx[NW-1] ^ den[NW-1];
      neg_y   <= numy[NW-1] ^ den[NW-1];
      lane    <= lc;
      last    <= tc;
    end
  end

  assign out_valid = vd;

endmodule

### rtl/lphf_div_step.sv
// ----------------------------------------------------------------------------
// lphf_div_step
// One restoring division stage for both quotients: compares each partial
// remainder with the shifted denominator and yields one quotient bit.
// ----------------------------------------------------------------------------
module lphf_div_step #(
  parameter int NW    = 45,
  parameter int QW    = 11,
  parameter int SHIFT = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [NW-1:0] in_den,
  input  logic [NW-1:0] in_rem_x,
  input  logic [NW-1:0] in_rem_y,
  input  logic [QW-1:0] in_q_x,
  input  logic [QW-1:0] in_q_y,
  input  logic          in_neg_x,
  input  logic          in_neg_y,
  input  logic          in_lane,
  input  logic          in_last,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [NW-1:0] out_den,
  output logic [NW-1:0] out_rem_x,
  output logic [NW-1:0] out_rem_y,
  output logic [QW-1:0] out_q_x,
  output logic [QW-1:0] out_q_y,
  output logic          out_neg_x,
  output logic          out_neg_y,
  output logic          out_lane,
  output logic          out_last
);

  localparam int TW = NW + QW + 1;

  logic          v;
  logic [TW-1:0] dsh, tx, ty;
  logic          bx, by;

  assign dsh = TW'(in_den) << SHIFT;
  assign tx  = TW'(in_rem_x) - dsh;
  assign ty  = TW'(in_rem_y) - dsh;
  assign bx  = !tx[TW-1];
  assign by  = !ty[TW-1];

  assign in_ready  = !v || out_ready;
  assign out_valid = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_den   <= in_den;
      out_rem_x <= bx ? tx[NW-1:0] : in_rem_x;
      out_rem_y <= by ? ty[NW-1:0] : in_rem_y;
      out_q_x   <= {in_q_x[QW-2:0], bx};
      out_q_y   <= {in_q_y[QW-2:0], by};
      out_neg_x <= in_neg_x;
      out_neg_y <= in_neg_y;
      out_lane  <= in_lane;
      out_last  <= in_last;
    end
  end

endmodule

### rtl/lphf_out.sv
// ----------------------------------------------------------------------------
// lphf_out
// Final stage: applies the quotient signs, adds the lateral offset, checks
// that the mapped point lies strictly inside the image and holds the result
// in the output register.
// ----------------------------------------------------------------------------
module lphf_out #(
  parameter int IMG_WIDTH  = 640,
  parameter int IMG_HEIGHT = 480,
  parameter int QB         = 10,
  parameter int XW         = 10,
  parameter int YW         = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  lphf_pkg::lphf_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [QB:0]         q_x,
  input  logic [QB:0]         q_y,
  input  logic                neg_x,
  input  logic                neg_y,
  input  logic                lane,
  input  logic                last,
  output logic                map_valid,
  input  logic                map_ready,
  output logic [XW-1:0]       map_x,
  output logic [YW-1:0]       map_y,
  output logic                map_lane,
  output logic                last_out
);

  localparam int SW = QB + 2;

  logic                 v;
  logic signed [SW-1:0] mx, my, sx, sy, px;
  logic                 keep;

  assign mx = $signed(SW'(q_x[QB-1:0]));
  assign my = $signed(SW'(q_y[QB-1:0]));
  assign sx = neg_x ? -mx : mx;
  assign sy = neg_y ? -my : my;
  assign px = sx + $signed(SW'(cfg.lateral_offset));

  // A set top quotient bit means the magnitude reached the clamp range, so
  // the point cannot land inside the image.
  assign keep = !q_x[QB] && !q_y[QB] && (px > 0) && (px < IMG_WIDTH)
             && (sy > 0) && (sy < IMG_HEIGHT);

  assign in_ready  = !v || map_ready;
  assign map_valid = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      map_x    <= px[XW-1:0];
      map_y    <= sy[YW-1:0];
      map_lane <= lane;
      last_out <= last;
    end
  end

endmodule

### rtl/lane_point_homography_filter.sv
// ----------------------------------------------------------------------------
// lane_point_homography_filter
// Maps lane pixel points to a bird's-eye view through a projective
// homography, adds a lateral offset and keeps only points inside the image.
// ----------------------------------------------------------------------------
// The block takes one point per clock cycle and keeps that rate for as long
// as results are taken. A point passes through 6 + QB register stages, where
// QB is the larger of the coordinate width and the offset width: window
// check, four coefficient products, numerator sums, magnitudes, QB + 1
// restoring division stages that each settle one quotient bit of both
// coordinates, and the output register. Dropped points leave empty slots
// behind, and back pressure is passed upstream combinationally through the
// ready chain, so a waiting result does not stop new transfers while
// earlier stages have room.
module lane_point_homography_filter #(
  parameter int IMG_WIDTH      = 640,
  parameter int IMG_HEIGHT     = 480,
  parameter int COEF_FRAC_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lphf_pkg::ADDR_W-1:0]   paddr,
  input  logic [lphf_pkg::DATA_W-1:0]   pwdata,
  output logic [lphf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          pt_valid,
  output logic                          pt_ready,
  input  logic signed [15:0]            pix_x,
  input  logic signed [15:0]            pix_y,
  input  logic                          lane_sel,
  input  logic                          last_in,
  output logic                          map_valid,
  input  logic                          map_ready,
  output logic [$clog2(IMG_WIDTH)-1:0]  map_x,
  output logic [$clog2(IMG_HEIGHT)-1:0] map_y,
  output logic                          map_lane,
  output logic                          last_out
);

  localparam int CW = $clog2((IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT);
  localparam int QB = (CW > lphf_pkg::OFS_W) ? CW : lphf_pkg::OFS_W;
  localparam int QW = QB + 1;
  localparam int NW = lphf_pkg::COEF_W + CW + 3;
  localparam int XW = $clog2(IMG_WIDTH);
  localparam int YW = $clog2(IMG_HEIGHT);

  lphf_pkg::lphf_cfg_t cfg;

  logic [QW:0]   sv, sr;
  logic [NW-1:0] s_den   [0:QW];
  logic [NW-1:0] s_rem_x [0:QW];
  logic [NW-1:0] s_rem_y [0:QW];
  logic [QW-1:0] s_q_x   [0:QW];
  logic [QW-1:0] s_q_y   [0:QW];
  logic [QW:0]   s_neg_x, s_neg_y, s_lane, s_last;

  lphf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lphf_front #(
    .IMG_WIDTH      (IMG_WIDTH),
    .IMG_HEIGHT     (IMG_HEIGHT),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .CW             (CW),
    .NW             (NW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .lane_sel  (lane_sel),
    .last_in   (last_in),
    .out_valid (sv[0]),
    .out_ready (sr[0]),
    .den_mag   (s_den[0]),
    .mag_x     (s_rem_x[0]),
    .mag_y     (s_rem_y[0]),
    .neg_x     (s_neg_x[0]),
    .neg_y     (s_neg_y[0]),
    .lane      (s_lane[0]),
    .last      (s_last[0])
  );

  assign s_q_x[0] = '0;
  assign s_q_y[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    lphf_div_step #(
      .NW    (NW),
      .QW    (QW),
      .SHIFT (QB - k)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sv[k]),
      .in_ready  (sr[k]),
      .in_den    (s_den[k]),
      .in_rem_x  (s_rem_x[k]),
      .in_rem_y  (s_rem_y[k]),
      .in_q_x    (s_q_x[k]),
      .in_q_y    (s_q_y[k]),
      .in_neg_x  (s_neg_x[k]),
      .in_neg_y  (s_neg_y[k]),
      .in_lane   (s_lane[k]),
      .in_last   (s_last[k]),
      .out_valid (sv[k+1]),
      .out_ready (sr[k+1]),
      .out_den   (s_den[k+1]),
      .out_rem_x (s_rem_x[k+1]),
      .out_rem_y (s_rem_y[k+1]),
      .out_q_x   (s_q_x[k+1]),
      .out_q_y   (s_q_y[k+1]),
      .out_neg_x (s_neg_x[k+1]),
      .out_neg_y (s_neg_y[k+1]),
      .out_lane  (s_lane[k+1]),
      .out_last  (s_last[k+1])
    );
  end

  lphf_out #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT),
    .QB         (QB),
    .XW         (XW),
    .YW         (YW)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sv[QW]),
    .in_ready  (sr[QW]),
    .q_x       (s_q_x[QW]),
    .q_y       (s_q_y[QW]),
    .neg_x     (s_neg_x[QW]),
    .neg_y     (s_neg_y[QW]),
    .lane      (s_lane[QW]),
    .last      (s_last[QW]),
    .map_valid (map_valid),
    .map_ready (map_ready),
    .map_x     (map_x),
    .map_y     (map_y),
    .map_lane  (map_lane),
    .last_out  (last_out)
  );

endmodule

### rtl/lphf_checker.sv
// ----------------------------------------------------------------------------
// lphf_checker
// Port-level checks for the lane point homography filter, bound to the top
// level.
// ----------------------------------------------------------------------------
module lphf_checker #(
  parameter int IMG_WIDTH  = 640,
  parameter int IMG_HEIGHT = 480
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          map_valid,
  input logic                          map_ready,
  input logic [$clog2(IMG_WIDTH)-1:0]  map_x,
  input logic [$clog2(IMG_HEIGHT)-1:0] map_y,
  input logic                          map_lane,
  input logic                          last_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    map_valid && !map_ready |=> map_valid && $stable(map_x) && $stable(map_y)
      && $stable(map_lane) && $stable(last_out))
    else $error("result changed before its transfer completed");

  a_x_inside: assert property (@(posedge clk) disable iff (rst)
    map_valid |-> (map_x != 0) && (map_x < IMG_WIDTH))
    else $error("mapped column outside the image");

  a_y_inside: assert property (@(posedge clk) disable iff (rst)
    map_valid |-> (map_y != 0) && (map_y < IMG_HEIGHT))
    else $error("mapped row outside the image");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !map_valid)
    else $error("result offered straight after reset");

endmodule

bind lane_point_homography_filter lphf_checker #(
  .IMG_WIDTH  (IMG_WIDTH),
  .IMG_HEIGHT (IMG_HEIGHT)
) u_lphf_checker (
  .clk       (clk),
  .rst       (rst),
  .map_valid (map_valid),
  .map_ready (map_ready),
  .map_x     (map_x),
  .map_y     (map_y),
  .map_lane  (map_lane),
  .last_out  (last_out)
);
